FILE: design/pdo_rx_pkg.sv
package pdo_rx_pkg;

  localparam logic [1:0] CMD_FRAME  = 2'd0;
  localparam logic [1:0] CMD_ASSIGN = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] CLS_UNKNOWN = 2'd0;
  localparam logic [1:0] CLS_DI      = 2'd1;
  localparam logic [1:0] CLS_DO      = 2'd2;
  localparam logic [1:0] CLS_ANALOG  = 2'd3;

  localparam logic [2:0] ST_IGNORED     = 3'd0;
  localparam logic [2:0] ST_UNKNOWN     = 3'd1;
  localparam logic [2:0] ST_DI_STORED   = 3'd2;
  localparam logic [2:0] ST_DO_STORED   = 3'd3;
  localparam logic [2:0] ST_ANALOG_LOW  = 3'd4;
  localparam logic [2:0] ST_ANALOG_HIGH = 3'd5;
  localparam logic [2:0] ST_ASSIGNED    = 3'd6;
  localparam logic [2:0] ST_READ        = 3'd7;

  localparam logic [10:0] PDO1_FIRST = 11'h180;
  localparam logic [10:0] PDO1_LAST  = 11'h1FF;
  localparam logic [10:0] PDO2_FIRST = 11'h280;
  localparam logic [10:0] PDO2_LAST  = 11'h2FF;

  localparam int         ANALOG_CHANNELS = 8;
  localparam logic [3:0] CH_DIGITAL      = 4'd8;
  localparam int         IMG_SLOTS       = 32;

  typedef struct packed {
    logic [1:0]  node_class;
    logic [4:0]  slot;
    logic [1:0]  half_seen;
    logic [15:0] out_word;
  } node_entry_t;

endpackage

FILE: design/pdo_rx_in_if.sv
interface pdo_rx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [10:0] can_id;
  logic [63:0] payload;
  logic [6:0]  node_id;
  logic [1:0]  node_class;
  logic [4:0]  input_slot;
  logic [3:0]  channel;

  modport source (
    output valid, command, can_id, payload, node_id, node_class, input_slot, channel,
    input  ready
  );
  modport sink (
    input  valid, command, can_id, payload, node_id, node_class, input_slot, channel,
    output ready
  );
endinterface

FILE: design/pdo_rx_out_if.sv
interface pdo_rx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  source_node;
  logic [15:0] word;
  logic        both_halves_seen;

  modport source (
    output valid, status, source_node, word, both_halves_seen,
    input  ready
  );
  modport sink (
    input  valid, status, source_node, word, both_halves_seen,
    output ready
  );
endinterface

FILE: design/pdo_rx_store.sv
module pdo_rx_store #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_mem_r;
  logic             rd_vld_r;
  logic             fwd_hit_r;
  logic [WIDTH-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // A write in the same cycle as the read supplies the newer value.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r   <= vld_r[rd_addr];
      fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : (rd_vld_r ? rd_mem_r : '0);

endmodule

FILE: design/pdo_receive_dispatch_core.sv
// Pipeline: an accepted word is held in the stage-one registers and moves to the result
// register when the output can advance. Throughput: one word per cycle unless out_ch.ready
// stalls; the node table and analog store are each read once and written once per cycle,
// with write-to-read forwarding. Reset: synchronous, active low; the node table and analog
// store read as zero through per-entry valid bits, the image is cleared, both stages empty.
module pdo_receive_dispatch_core import pdo_rx_pkg::*; #(
  parameter int NODES       = 32,
  parameter int INPUT_SLOTS = 32
) (
  input logic          clk,
  input logic          rst_n,
  pdo_rx_in_if.sink    in_ch,
  pdo_rx_out_if.source out_ch
);

  localparam int NODE_DEPTH = NODES + 1;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int ANA_DEPTH  = 2 * NODE_DEPTH;
  localparam int ANA_AW     = $clog2(ANA_DEPTH);

  logic        in_acc;
  logic        a_pdo1;
  logic        a_pdo2;
  logic [6:0]  a_node;
  logic        a_ok;

  logic        s1_valid_r;
  logic [1:0]  cmd_r;
  logic        hit_r;
  logic        half_r;
  logic [6:0]  node_r;
  logic        ok_r;
  logic [63:0] payload_r;
  logic [1:0]  class_r;
  logic [4:0]  slot_r;
  logic [3:0]  channel_r;

  logic        adv;
  logic        s1_fire;

  node_entry_t node_rd;
  node_entry_t node_wd;
  logic        node_we;
  logic [63:0] ana_rd;
  logic        ana_we;
  logic        img_we;
  logic [1:0]  hs_new;
  logic        slot_in_range;

  logic [15:0] image_r [IMG_SLOTS];

  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [6:0]  source_r;
  logic [15:0] word_r;
  logic        both_r;
  logic [2:0]  status_nxt;
  logic [6:0]  source_nxt;
  logic [15:0] word_nxt;
  logic        both_nxt;

  assign adv          = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && adv;
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign a_pdo1 = (in_ch.can_id >= PDO1_FIRST) && (in_ch.can_id <= PDO1_LAST);
  assign a_pdo2 = (in_ch.can_id >= PDO2_FIRST) && (in_ch.can_id <= PDO2_LAST);
  assign a_node = (in_ch.command == CMD_FRAME) ? in_ch.can_id[6:0] : in_ch.node_id;
  assign a_ok   = (a_node != 7'd0) && (a_node <= 7'(NODES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= in_ch.command;
      hit_r     <= a_pdo1 || a_pdo2;
      half_r    <= a_pdo2;
      node_r    <= a_node;
      ok_r      <= a_ok;
      payload_r <= in_ch.payload;
      class_r   <= in_ch.node_class;
      slot_r    <= in_ch.input_slot;
      channel_r <= in_ch.channel;
    end
  end

  pdo_rx_store #(
    .WIDTH($bits(node_entry_t)),
    .DEPTH(NODE_DEPTH)
  ) u_node_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_acc && a_ok),
    .rd_addr(a_node[NODE_AW-1:0]),
    .rd_data(node_rd),
    .wr_en  (node_we),
    .wr_addr(node_r[NODE_AW-1:0]),
    .wr_data(node_wd)
  );

  pdo_rx_store #(
    .WIDTH(64),
    .DEPTH(ANA_DEPTH)
  ) u_analog_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_acc && a_ok),
    .rd_addr(ANA_AW'({a_node[NODE_AW-1:0], in_ch.channel[2]})),
    .rd_data(ana_rd),
    .wr_en  (ana_we),
    .wr_addr(ANA_AW'({node_r[NODE_AW-1:0], half_r})),
    .wr_data(payload_r)
  );

  assign slot_in_range = {2'b00, node_rd.slot} < 7'(INPUT_SLOTS);
  assign hs_new        = node_rd.half_seen | (half_r ? 2'b10 : 2'b01);

  always_comb begin
    status_nxt = ST_IGNORED;
    source_nxt = node_r;
    word_nxt   = '0;
    both_nxt   = 1'b0;
    node_wd    = node_rd;
    node_we    = 1'b0;
    ana_we     = 1'b0;
    img_we     = 1'b0;
    case (cmd_r)
      CMD_FRAME: begin
        if (!hit_r) begin
          source_nxt = '0;
        end else if (ok_r) begin
          case (node_rd.node_class)
            CLS_DI: begin
              status_nxt = ST_DI_STORED;
              word_nxt   = payload_r[15:0];
              img_we     = s1_fire && slot_in_range;
            end
            CLS_DO: begin
              status_nxt       = ST_DO_STORED;
              word_nxt         = payload_r[15:0];
              node_wd.out_word = payload_r[15:0];
              node_we          = s1_fire;
            end
            CLS_ANALOG: begin
              status_nxt        = half_r ? ST_ANALOG_HIGH : ST_ANALOG_LOW;
              word_nxt          = payload_r[15:0];
              both_nxt          = (hs_new == 2'b11);
              node_wd.half_seen = hs_new;
              node_we           = s1_fire;
              ana_we            = s1_fire;
            end
            default: begin
              status_nxt = ST_UNKNOWN;
            end
          endcase
        end
      end
      CMD_ASSIGN: begin
        if (ok_r) begin
          status_nxt         = ST_ASSIGNED;
          node_wd.node_class = class_r;
          node_wd.slot       = slot_r;
          node_we            = s1_fire;
        end
      end
      CMD_READ: begin
        if (ok_r) begin
          status_nxt = ST_READ;
          both_nxt   = (node_rd.half_seen == 2'b11);
          if (channel_r < 4'(ANALOG_CHANNELS)) begin
            word_nxt = ana_rd[{channel_r[1:0], 4'b0000} +: 16];
          end else if (channel_r == CH_DIGITAL) begin
            if (node_rd.node_class == CLS_DI) begin
              word_nxt = slot_in_range ? image_r[node_rd.slot] : 16'd0;
            end else begin
              word_nxt = node_rd.out_word;
            end
          end
        end
      end
      default: begin
        source_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IMG_SLOTS; i++) begin
        image_r[i] <= '0;
      end
    end else if (img_we) begin
      image_r[node_rd.slot] <= payload_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      status_r <= status_nxt;
      source_r <= source_nxt;
      word_r   <= word_nxt;
      both_r   <= both_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.source_node      = source_r;
  assign out_ch.word             = word_r;
  assign out_ch.both_halves_seen = both_r;

endmodule

FILE: design/pdo_rx_checker.sv
module pdo_rx_checker import pdo_rx_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [15:0] word,
  input logic        both
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(word))
    else $error("result word changed while stalled");

  // The input side only stalls when a result is stuck at the output.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_IGNORED || status == ST_UNKNOWN || status == ST_ASSIGNED)
    |-> word == 16'd0 && !both)
    else $error("ignored, unknown or assign result carries data");

  a_digital_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_DI_STORED || status == ST_DO_STORED) |-> !both)
    else $error("digital result reports both halves");

endmodule

bind pdo_receive_dispatch_core pdo_rx_checker u_pdo_rx_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .status   (out_ch.status),
  .word     (out_ch.word),
  .both     (out_ch.both_halves_seen)
);
